// ===== rtl/rhc_pkg.sv =====
`default_nettype none
package rhc_pkg;

  localparam int CH_W        = 8;   // input channel width
  localparam int HUE_QW      = 9;   // hue quotient bits
  localparam int SAT_QW      = 8;   // saturation quotient bits
  localparam int HUE_NW      = 17;  // hue dividend bits, below 360*255
  localparam int SAT_NW      = 16;  // saturation dividend bits, up to 255*255
  localparam int NUM_W       = 19;  // signed working width of the hue numerator
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int BACK_STAGES = HUE_QW;

  localparam int HUE_SECTOR       = 60;
  localparam int HUE_GREEN_OFFSET = 120;
  localparam int HUE_BLUE_OFFSET  = 240;
  localparam int HUE_FULL_TURN    = 360;
  localparam int SAT_SCALE        = 255;

  // One classified pixel, ready for the two divisions.
  typedef struct packed {
    logic [HUE_NW-1:0] hue_num;
    logic [CH_W-1:0]   hue_div;   // max - min
    logic [SAT_NW-1:0] sat_num;
    logic [CH_W-1:0]   sat_div;   // max, also the brightness
  } rhc_entry_t;

  // One stage of the divider pipeline.
  typedef struct packed {
    logic              valid;
    logic [HUE_NW-1:0] hue_rem;
    logic [CH_W-1:0]   hue_div;
    logic [HUE_QW-1:0] hue_q;
    logic [SAT_NW-1:0] sat_rem;
    logic [CH_W-1:0]   sat_div;
    logic [SAT_QW-1:0] sat_q;
  } rhc_stage_t;

endpackage
`default_nettype wire

// ===== rtl/rhc_front.sv =====
`default_nettype none
module rhc_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_red,
  input  wire logic [7:0]           in_green,
  input  wire logic [7:0]           in_blue,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output rhc_pkg::rhc_entry_t       push_entry
);
  import rhc_pkg::*;

  localparam logic signed [NUM_W-1:0] SectorS = NUM_W'(HUE_SECTOR);
  localparam logic signed [NUM_W-1:0] TurnS   = NUM_W'(HUE_FULL_TURN);

  logic                     front_valid_r, front_valid_nxt;
  rhc_entry_t               front_r;
  rhc_entry_t               entry_nxt;
  logic [CH_W-1:0]          mx, mn;
  logic signed [CH_W:0]     diff;
  logic [CH_W-1:0]          off;
  logic [CH_W-1:0]          delta;
  logic signed [NUM_W-1:0]  delta_s, off_s, diff_s, num, wrapped;
  logic                     take;

  assign in_ready   = !front_valid_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = front_valid_r;
  assign push_entry = front_r;

  // Classify the dominant channel; ties go to red, then green.
  always_comb begin
    if (in_red >= in_green && in_red >= in_blue) begin
      mx   = in_red;
      mn   = (in_green < in_blue) ? in_green : in_blue;
      diff = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
      off  = '0;
    end else if (in_green >= in_blue) begin
      mx   = in_green;
      mn   = (in_red < in_blue) ? in_red : in_blue;
      diff = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
      off  = CH_W'(HUE_GREEN_OFFSET);
    end else begin
      mx   = in_blue;
      mn   = (in_red < in_green) ? in_red : in_green;
      diff = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
      off  = CH_W'(HUE_BLUE_OFFSET);
    end
    delta   = mx - mn;
    delta_s = signed'({{(NUM_W-CH_W){1'b0}}, delta});
    off_s   = signed'({{(NUM_W-CH_W){1'b0}}, off});
    diff_s  = NUM_W'(diff);
    num     = off_s * delta_s + SectorS * diff_s;
    // Wrap a negative hue by one full turn
    wrapped = (num < 0) ? (num + TurnS * delta_s) : num;
    entry_nxt.hue_num = wrapped[HUE_NW-1:0];
    entry_nxt.hue_div = delta;
    entry_nxt.sat_num = SAT_NW'(delta) * SAT_NW'(SAT_SCALE);
    entry_nxt.sat_div = mx;
  end

  always_comb begin
    front_valid_nxt = front_valid_r;
    if (take) begin
      front_valid_nxt = 1'b1;
    end else if (push_ready) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
    if (take) begin
      front_r <= entry_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rhc_queue.sv =====
`default_nettype none
module rhc_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push_valid,
  output logic                      push_ready,
  input  wire rhc_pkg::rhc_entry_t  push_entry,
  output logic                      pop_valid,
  input  wire logic                 pop_ready,
  output rhc_pkg::rhc_entry_t       pop_entry
);
  import rhc_pkg::*;

  rhc_entry_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;
  logic                push, pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rhc_back.sv =====
`default_nettype none
module rhc_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 pop_valid,
  output logic                      pop_ready,
  input  wire rhc_pkg::rhc_entry_t  pop_entry,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [8:0]                out_hue,
  output logic [7:0]                out_saturation,
  output logic [7:0]                out_brightness
);
  import rhc_pkg::*;

  localparam int Last = BACK_STAGES - 1;

  rhc_stage_t  st_r   [BACK_STAGES];
  rhc_stage_t  st_nxt [BACK_STAGES];
  rhc_stage_t  st_in  [BACK_STAGES];
  logic        advance;

  // Advance the whole divider line together unless the result is held.
  assign advance   = !st_r[Last].valid || out_ready;
  assign pop_ready = advance;

  always_comb begin
    st_in[0].valid   = pop_valid;
    st_in[0].hue_rem = pop_entry.hue_num;
    st_in[0].hue_div = pop_entry.hue_div;
    st_in[0].hue_q   = '0;
    st_in[0].sat_rem = pop_entry.sat_num;
    st_in[0].sat_div = pop_entry.sat_div;
    st_in[0].sat_q   = '0;
    for (int s = 1; s < BACK_STAGES; s++) begin
      st_in[s] = st_r[s-1];
    end
  end

  // One quotient bit per stage, most significant first; saturation skips stage 0.
  always_comb begin
    for (int s = 0; s < BACK_STAGES; s++) begin
      logic [HUE_NW-1:0] hsh;
      logic [SAT_NW-1:0] ssh;
      st_nxt[s] = st_in[s];
      hsh = HUE_NW'(st_in[s].hue_div) << (HUE_QW - 1 - s);
      ssh = SAT_NW'(st_in[s].sat_div) << (HUE_QW - 1 - s);
      if (st_in[s].hue_div != '0 && st_in[s].hue_rem >= hsh) begin
        st_nxt[s].hue_rem = st_in[s].hue_rem - hsh;
        st_nxt[s].hue_q[HUE_QW-1-s] = 1'b1;
      end
      if (HUE_QW - 1 - s < SAT_QW) begin
        if (st_in[s].sat_div != '0 && st_in[s].sat_rem >= ssh) begin
          st_nxt[s].sat_rem = st_in[s].sat_rem - ssh;
          st_nxt[s].sat_q   = st_in[s].sat_q | SAT_QW'(1 << (HUE_QW - 1 - s));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < BACK_STAGES; s++) begin
        st_r[s].valid <= 1'b0;
      end
    end else if (advance) begin
      for (int s = 0; s < BACK_STAGES; s++) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign out_valid      = st_r[Last].valid;
  assign out_hue        = st_r[Last].hue_q;
  assign out_saturation = st_r[Last].sat_q;
  assign out_brightness = st_r[Last].sat_div;

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue < 9'(HUE_FULL_TURN)))
    else $error("hue out of range");

  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_brightness == '0) |-> (out_saturation == '0 && out_hue == '0))
    else $error("black pixel with nonzero hue or saturation");

  a_hold_line: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r[Last].valid && !out_ready) |=> $stable(st_r[0].valid) && $stable(st_r[Last]))
    else $error("divider line moved while stalled");

endmodule
`default_nettype wire

// ===== rtl/rgb_to_hsv_converter_top.sv =====
`default_nettype none
// Channel   Direction  Ports                                        Transfer
// input     in         in_valid, in_ready, in_red/green/blue        valid && ready
// result    out        out_valid, out_ready, out_hue/saturation/    valid && ready
//                      out_brightness
//
// One pixel per clock while out_ready is high; the divider line sets the rate.
// With no stall, an accepted pixel passes the classifier register, one queue
// slot and the nine stages of the divider line before its result is valid.
// Reset is synchronous and clears valid flags, queue pointers and count only.
// A stalled result holds the divider line; the four-entry queue and the front
// register keep taking pixels until they fill.
module rgb_to_hsv_converter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [8:0]       out_hue,
  output logic [7:0]       out_saturation,
  output logic [7:0]       out_brightness
);
  import rhc_pkg::*;

  logic        push_valid, push_ready;
  rhc_entry_t  push_entry;
  logic        pop_valid, pop_ready;
  rhc_entry_t  pop_entry;

  // Front: pick the dominant channel, form both dividends and divisors.
  rhc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // Queue: decouple the classifier from the divider line.
  rhc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // Back: pipelined restoring division for hue and saturation; the last
  // stage doubles as the output register.
  rhc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_entry      (pop_entry),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

endmodule
`default_nettype wire
